// ===== rtl/core/eot_pkg.sv =====
// Shared types, constants and helper functions of the elevator order table.
package eot_pkg;

	localparam int FLOORS  = 4;
	localparam int ROWS    = 3;
	localparam int OP_W    = 2;
	localparam int BTN_W   = 2;
	localparam int FLOOR_W = 2;
	localparam int MDIR_W  = 2;
	localparam int ORDER_W = ROWS * FLOORS;
	localparam int CNT_W   = $clog2(ORDER_W + 1);
	localparam int ITEM_W  = OP_W + BTN_W + FLOOR_W + MDIR_W;
	localparam int RES_W   = 3 + ORDER_W;

	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PRESS     = 2'd0;
	localparam logic [OP_W-1:0] OP_CLR_FLOOR = 2'd1;
	localparam logic [OP_W-1:0] OP_CLR_ALL   = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

	localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
	localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
	localparam logic [BTN_W-1:0] BTN_CAB  = 2'd2;

	localparam logic [MDIR_W-1:0] MD_IDLE = 2'b00;
	localparam logic [MDIR_W-1:0] MD_UP   = 2'b01;
	localparam logic [MDIR_W-1:0] MD_DOWN = 2'b11;

	typedef logic [FLOORS-1:0] row_t;
	typedef logic [ROWS-1:0][FLOORS-1:0] rows_t;

	// Packed so that the last field sits in the lowest bits.
	typedef struct packed {
		logic signed [MDIR_W-1:0] motor_dir;
		logic [FLOOR_W-1:0]       floor;
		logic [BTN_W-1:0]         button;
		logic [OP_W-1:0]          operation;
	} item_t;

	typedef struct packed {
		logic [ORDER_W-1:0] order_bits;
		logic               stop_here;
		logic               head_up;
		logic               any_pending;
	} result_t;

	function automatic logic floor_ok(input logic [FLOOR_W-1:0] fl);
		return 32'(fl) < FLOORS;
	endfunction

	// One-hot mask of the given floor, empty when the floor does not exist.
	function automatic row_t floor_onehot(input logic [FLOOR_W-1:0] fl);
		row_t m;
		m = '0;
		for (int f = 0; f < FLOORS; f++) begin
			m[f] = (32'(fl) == f);
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/eot_table.sv =====
// Order bit storage: applies press and clear operations to the three rows.
module eot_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  eot_pkg::item_t      item,
	output eot_pkg::rows_t      rows_next
);

	eot_pkg::rows_t rows_q;
	eot_pkg::row_t  here;

	assign here = eot_pkg::floor_onehot(item.floor);

	always_comb begin
		rows_next = rows_q;
		unique case (item.operation)
			eot_pkg::OP_PRESS: begin
				for (int b = 0; b < eot_pkg::ROWS; b++) begin
					if (32'(item.button) == b) begin
						rows_next[b] = rows_q[b] | here;
					end
				end
			end
			eot_pkg::OP_CLR_FLOOR: begin
				for (int b = 0; b < eot_pkg::ROWS; b++) begin
					rows_next[b] = rows_q[b] & ~here;
				end
			end
			eot_pkg::OP_CLR_ALL: begin
				rows_next = '0;
			end
			eot_pkg::OP_QUERY: begin
				rows_next = rows_q;
			end
			default: begin
				rows_next = rows_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (upd) begin
			rows_q <= rows_next;
		end
	end

endmodule

// ===== rtl/core/eot_decide.sv =====
// Direction, stop and pending decisions from the updated order table.
module eot_decide (
	input  logic                               rows_valid,
	input  eot_pkg::rows_t                     rows,
	input  logic [eot_pkg::FLOOR_W-1:0]        floor,
	input  logic signed [eot_pkg::MDIR_W-1:0]  motor_dir,
	output eot_pkg::result_t                   result
);

	eot_pkg::row_t             here;
	eot_pkg::row_t             above;
	eot_pkg::row_t             below;
	eot_pkg::row_t             hall;
	logic                      fl_ok;
	logic [eot_pkg::CNT_W-1:0] up_cnt;
	logic [eot_pkg::CNT_W-1:0] total;
	logic                      up_here;
	logic                      dn_here;
	logic                      cab_here;
	logic                      stop;

	assign fl_ok = eot_pkg::floor_ok(floor);
	assign here  = eot_pkg::floor_onehot(floor);
	assign hall  = rows[0] | rows[1];

	// Floors strictly above the given one, and strictly below it.
	always_comb begin
		for (int f = 0; f < eot_pkg::FLOORS; f++) begin
			above[f] = fl_ok && (f > 32'(floor));
			below[f] = !fl_ok || (f < 32'(floor));
		end
	end

	always_comb begin
		up_cnt = '0;
		total  = '0;
		for (int b = 0; b < eot_pkg::ROWS; b++) begin
			for (int f = 0; f < eot_pkg::FLOORS; f++) begin
				up_cnt = up_cnt + eot_pkg::CNT_W'(rows[b][f] & above[f]);
				total  = total + eot_pkg::CNT_W'(rows[b][f]);
			end
		end
	end

	assign up_here  = |(rows[0] & here);
	assign dn_here  = |(rows[1] & here);
	assign cab_here = |(rows[2] & here);

	always_comb begin
		stop = 1'b0;
		if (cab_here) begin
			stop = 1'b1;
		end else begin
			unique case (motor_dir)
				eot_pkg::MD_IDLE: stop = up_here || dn_here;
				eot_pkg::MD_UP:   stop = up_here || (dn_here && !(|(hall & above)));
				eot_pkg::MD_DOWN: stop = dn_here || (up_here && !(|(hall & below)));
				default:          stop = 1'b0;
			endcase
		end
	end

	// More orders above than at or below: twice the upper count beats the total.
	always_comb begin
		result.any_pending = rows_valid && (total != '0);
		result.head_up     = rows_valid &&
			({up_cnt, 1'b0} > {1'b0, total});
		result.stop_here   = rows_valid && stop;
		result.order_bits  = rows;
	end

endmodule

// ===== rtl/core/elevator_order_table.sv =====
// Top level of the elevator order table: input register, table update and result register.
// A request accepted into the input register moves on into the result register once that
// register is empty or its result is being taken, and m_tvalid rises when it is loaded.
// Throughput: one request per cycle while results are taken; the table update plus
// popcount and stop logic sit between the input register and the result register.
// s_tready drops only while both the input and result registers are full
// and the result is not being taken.
// Reset (arst_n low) clears all order bits and empties both registers.
module elevator_order_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation[1:0], button[3:2], floor[5:4], motor_dir[7:6]
	input  logic [eot_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// any_pending[0], head_up[1], stop_here[2], order_bits[14:3], zero pad above
	output logic [eot_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	eot_pkg::item_t   item_s1;
	logic             valid_s1;
	eot_pkg::rows_t   rows_next;
	eot_pkg::result_t result;
	eot_pkg::result_t res_q;
	logic             m_valid_q;
	logic             s_acc;
	logic             advance;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1 <= eot_pkg::item_t'(s_tdata[eot_pkg::ITEM_W-1:0]);
		end
	end

	eot_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance),
		.item      (item_s1),
		.rows_next (rows_next)
	);

	eot_decide u_decide (
		.rows_valid (1'b1),
		.rows       (rows_next),
		.floor      (item_s1.floor),
		.motor_dir  (item_s1.motor_dir),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = eot_pkg::OUT_TDATA_W'(res_q);

endmodule

// ===== rtl/core/eot_checker.sv =====
// Port-level assertions for the elevator order table, bound to the top level.
module eot_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [eot_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [eot_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic       res_pending;
	logic       res_head;
	logic       res_stop;
	logic       orders_set;

	assign res_pending = m_tdata[0];
	assign res_head    = m_tdata[1];
	assign res_stop    = m_tdata[2];
	assign orders_set  = |m_tdata[eot_pkg::RES_W-1:3];

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// The input side stalls only behind a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// The pending flag agrees with the reported order bits.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_pending == orders_set))
		else $error("pending flag disagrees with order bits");

	// Stopping or heading up needs at least one order.
	a_need_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_stop || res_head) |-> res_pending)
		else $error("decision without any order");

	// An accepted emergency clear shows an empty table in its result when the output is ready to move it on.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready &&
			(s_tdata[eot_pkg::OP_W-1:0] == eot_pkg::OP_CLR_ALL)) ##1 m_tready
		|=> m_tvalid && !res_pending && !orders_set)
		else $error("clear all left orders behind");

endmodule

bind elevator_order_table eot_checker u_eot_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the elevator order table with a scoreboard class.
module testbench;
	import eot_pkg::*;

	// Codes that the package leaves unnamed: a button kind with no row and a motion pattern
	// that is neither up, down nor idle.
	localparam logic [BTN_W-1:0]  BTN_NONE = 2'd3;
	localparam logic [MDIR_W-1:0] MD_BAD   = 2'b10;
	localparam int                STALL_LIMIT = 2000;
	localparam int                HOLD_OFF_CYCLES = 300;

	// Keeps its own copy of the call table, computes what each request should report and
	// compares the block's results against those in order.
	class dispatch_check;
		rows_t   calls;
		result_t awaiting[$];
		int      errors;
		int      checked;
		int      stops_seen;
		int      ups_seen;

		function new();
			calls = '0;
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		// Applies one request to the table and works out the decision it should produce.
		function result_t dispatch_decision(item_t it);
			row_t    here, above, below, hall;
			logic    fl_ok, up_h, dn_h, cab_h, stop;
			int      up_cnt, total;
			result_t res;
			fl_ok = int'(it.floor) < FLOORS;
			here = '0;
			if (fl_ok) begin
				here[it.floor] = 1'b1;
			end
			case (it.operation)
				OP_PRESS: begin
					if (int'(it.button) < ROWS && fl_ok) begin
						calls[it.button] = calls[it.button] | here;
					end
				end
				OP_CLR_FLOOR: begin
					for (int b = 0; b < ROWS; b++) begin
						calls[b] = calls[b] & ~here;
					end
				end
				OP_CLR_ALL: calls = '0;
				default: ;
			endcase
			for (int f = 0; f < FLOORS; f++) begin
				above[f] = fl_ok && f > int'(it.floor);
				below[f] = !fl_ok || f < int'(it.floor);
			end
			up_cnt = 0;
			total = 0;
			for (int b = 0; b < ROWS; b++) begin
				for (int f = 0; f < FLOORS; f++) begin
					if (calls[b][f]) begin
						total++;
						if (above[f]) begin
							up_cnt++;
						end
					end
				end
			end
			up_h  = |(calls[BTN_UP] & here);
			dn_h  = |(calls[BTN_DOWN] & here);
			cab_h = |(calls[BTN_CAB] & here);
			hall  = calls[BTN_UP] | calls[BTN_DOWN];
			if (cab_h) begin
				stop = 1'b1;
			end else if (it.motor_dir == MD_IDLE) begin
				stop = up_h || dn_h;
			end else if (it.motor_dir == MD_UP) begin
				stop = up_h || (dn_h && (hall & above) == '0);
			end else if (it.motor_dir == MD_DOWN) begin
				stop = dn_h || (up_h && (hall & below) == '0);
			end else begin
				stop = 1'b0;
			end
			res.any_pending = total != 0;
			res.head_up     = up_cnt > total - up_cnt;
			res.stop_here   = stop;
			res.order_bits  = calls;
			return res;
		endfunction

		function void note_request(item_t it);
			awaiting.push_back(dispatch_decision(it));
		endfunction

		task check_result(result_t got);
			result_t want;
			checked++;
			if (awaiting.size() == 0) begin
				report("result with nothing outstanding", 1, 0);
			end else begin
				want = awaiting.pop_front();
				stops_seen += want.stop_here;
				ups_seen += want.head_up;
				if (got.any_pending !== want.any_pending)
					report("any_pending", got.any_pending, want.any_pending);
				if (got.head_up !== want.head_up)
					report("head_up", got.head_up, want.head_up);
				if (got.stop_here !== want.stop_here)
					report("stop_here", got.stop_here, want.stop_here);
				if (got.order_bits !== want.order_bits)
					report("order_bits", got.order_bits, want.order_bits);
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	dispatch_check board = new();
	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	bit  hold_off = 1'b0;
	int  quiet_cycles = 0;
	int  sent = 0;

	elevator_order_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
	end

	// Handshake signals are stable at the falling edge, so a request or result seen here is
	// taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_result(result_t'(m_tdata[RES_W-1:0]));
		end
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic item_t req(logic [OP_W-1:0] op, logic [BTN_W-1:0] btn,
			int fl, logic [MDIR_W-1:0] md);
		item_t it;
		it.operation = op;
		it.button    = btn;
		it.floor     = FLOOR_W'(fl);
		it.motor_dir = md;
		return it;
	endfunction

	// Mostly presses and queries so the table fills, with floor clears and a rare clear-all.
	function automatic item_t random_request();
		int               pick;
		logic [OP_W-1:0]  op;
		logic [BTN_W-1:0] btn;
		pick = $urandom_range(99);
		if (pick < 45) op = OP_PRESS;
		else if (pick < 65) op = OP_CLR_FLOOR;
		else if (pick < 95) op = OP_QUERY;
		else op = OP_CLR_ALL;
		btn = ($urandom_range(19) == 0) ? BTN_NONE : BTN_W'($urandom_range(2));
		return req(op, btn, $urandom_range(FLOORS - 1), MDIR_W'($urandom_range(3)));
	endfunction

	// Called just after a rising edge; returns just after the edge that took the request.
	task send_request(item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(it);
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		board.note_request(it);
		sent++;
		@(posedge clk);
	endtask

	task run_phase(int idle_pct, int stall_pct, int count);
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		repeat (count) send_request(random_request());
	endtask

	task wait_drained();
		while (board.awaiting.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	initial begin
		item_t directed[$];
		directed = '{
			req(OP_CLR_ALL,    BTN_UP,   0, MD_IDLE),
			req(OP_QUERY,      BTN_NONE, 3, MD_DOWN),
			req(OP_PRESS,      BTN_UP,   0, MD_IDLE),
			req(OP_PRESS,      BTN_DOWN, 3, MD_UP),
			req(OP_PRESS,      BTN_CAB,  3, MD_DOWN),
			req(OP_PRESS,      BTN_NONE, 2, MD_IDLE),
			req(OP_PRESS,      BTN_DOWN, 1, MD_IDLE),
			req(OP_QUERY,      BTN_UP,   1, MD_UP),
			req(OP_QUERY,      BTN_UP,   1, MD_DOWN),
			req(OP_QUERY,      BTN_CAB,  0, MD_DOWN),
			req(OP_QUERY,      BTN_UP,   0, MD_BAD),
			req(OP_QUERY,      BTN_DOWN, 3, MD_BAD),
			req(OP_PRESS,      BTN_UP,   2, MD_UP),
			req(OP_QUERY,      BTN_UP,   2, MD_DOWN),
			req(OP_QUERY,      BTN_DOWN, 2, MD_UP),
			req(OP_CLR_FLOOR,  BTN_NONE, 1, MD_BAD),
			req(OP_PRESS,      BTN_CAB,  0, MD_IDLE),
			req(OP_PRESS,      BTN_UP,   3, MD_UP),
			req(OP_PRESS,      BTN_DOWN, 0, MD_DOWN),
			req(OP_QUERY,      BTN_NONE, 0, MD_IDLE),
			req(OP_CLR_FLOOR,  BTN_CAB,  3, MD_UP),
			req(OP_CLR_ALL,    BTN_NONE, 3, MD_DOWN)
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) begin
			send_request(directed[i]);
		end

		run_phase(0, 0, 440);
		run_phase(70, 0, 440);
		run_phase(0, 70, 440);
		run_phase(34, 34, 440);

		// Hold the output off long enough that the block fills and stalls its input.
		fork
			begin
				@(negedge clk);
				hold_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		run_phase(0, 0, 60);

		// Stop offering requests until every outstanding result has come back.
		s_tvalid <= 1'b0;
		wait_drained();
		run_phase(34, 34, 60);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);

		$display("Sent %0d requests through idle, stall, mixed and hold-off phases; %0d results",
			sent, board.checked);
		$display("compared, %0d of them stopping the car and %0d heading up.",
			board.stops_seen, board.ups_seen);
		if (board.errors == 0 && board.awaiting.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
